// ----- hw/rtl/wide_antialiased_line_raster_top_assert.svh -----
// assertion macros for the antialiased line rasteriser
`ifndef WIDE_ANTIALIASED_LINE_RASTER_TOP_ASSERT_SVH
`define WIDE_ANTIALIASED_LINE_RASTER_TOP_ASSERT_SVH

// same-cycle implication
`define WALR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("walr: same-cycle check failed");

// next-cycle implication
`define WALR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("walr: next-cycle check failed");

`endif

// ----- hw/rtl/walr_pkg.sv -----
// types, constants and helper functions for the antialiased line rasteriser
package walr_pkg;

    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 16;
    localparam int ACC_BITS   = COORD_BITS + FRAC_BITS;
    localparam int WIDTH_BITS = 6;
    localparam int PIX_BITS   = 11;
    localparam int COV_BITS   = 8;
    localparam int QUO_BITS   = FRAC_BITS + 1;
    localparam int SLOPE_BITS = FRAC_BITS + 2;
    localparam int DIV_STEPS  = ACC_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [COV_BITS-1:0] COV_FULL = {COV_BITS{1'b1}};
    localparam logic [WIDTH_BITS-1:0] WIDTH_MIN = WIDTH_BITS'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                  start;
        logic [COORD_BITS-1:0] mag;
        logic [COORD_BITS-1:0] dx;
    } div_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [QUO_BITS-1:0] quotient;
    } div_rsp_t;

    // floor(g * 255 / 2^FRAC_BITS) for g in 0 .. 2^FRAC_BITS
    function automatic logic [COV_BITS-1:0] coverage_of(input logic [FRAC_BITS:0] g);
        logic [FRAC_BITS+COV_BITS:0] p;
        p = {g, {COV_BITS{1'b0}}} - {{COV_BITS{1'b0}}, g};
        return p[FRAC_BITS +: COV_BITS];
    endfunction

endpackage

// ----- hw/rtl/walr_cmd_if.sv -----
// command channel: load or step items
interface walr_cmd_if;
    logic                             valid;
    logic                             ready;
    logic                             command;
    logic [walr_pkg::COORD_BITS-1:0]  start_x;
    logic [walr_pkg::COORD_BITS-1:0]  start_y;
    logic [walr_pkg::COORD_BITS-1:0]  end_x;
    logic [walr_pkg::COORD_BITS-1:0]  end_y;
    logic [walr_pkg::WIDTH_BITS-1:0]  line_width;

    modport source (
        output valid, command, start_x, start_y, end_x, end_y, line_width,
        input  ready
    );

    modport sink (
        input  valid, command, start_x, start_y, end_x, end_y, line_width,
        output ready
    );
endinterface

// ----- hw/rtl/walr_pix_if.sv -----
// pixel channel: one rasterised pixel per transfer
interface walr_pix_if;
    logic                           valid;
    logic                           ready;
    logic [walr_pkg::PIX_BITS-1:0]  pixel_x;
    logic [walr_pkg::PIX_BITS-1:0]  pixel_y;
    logic [walr_pkg::COV_BITS-1:0]  coverage;
    logic                           interior;
    logic                           column_last;
    logic                           line_done;

    modport source (
        output valid, pixel_x, pixel_y, coverage, interior, column_last, line_done,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, coverage, interior, column_last, line_done,
        output ready
    );
endinterface

// ----- hw/rtl/walr_div.sv -----
// radix-2 restoring divider for the fixed-point slope
module walr_div (
    input  logic               clk,
    input  logic               rst_n,
    input  walr_pkg::div_req_t req,
    output walr_pkg::div_rsp_t rsp
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [walr_pkg::DIV_CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [walr_pkg::COORD_BITS-1:0]     rem_reg, rem_next;
    logic [walr_pkg::ACC_BITS-1:0]       quo_reg, quo_next;
    logic [walr_pkg::COORD_BITS-1:0]     dvsr_reg, dvsr_next;
    logic [walr_pkg::COORD_BITS:0]       trial;
    logic [walr_pkg::COORD_BITS:0]       diff;
    logic                                ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[walr_pkg::ACC_BITS-1]};
        diff  = trial - {1'b0, dvsr_reg};
        ge    = (trial >= {1'b0, dvsr_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvsr_next = dvsr_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = walr_pkg::DIV_CNT_BITS'(walr_pkg::DIV_STEPS - 1);
            rem_next  = '0;
            quo_next  = {req.mag, {walr_pkg::FRAC_BITS{1'b0}}};
            dvsr_next = req.dx;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[walr_pkg::COORD_BITS-1:0] : trial[walr_pkg::COORD_BITS-1:0];
            quo_next = {quo_reg[walr_pkg::ACC_BITS-2:0], ge};
            cnt_next = cnt_reg - walr_pkg::DIV_CNT_BITS'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvsr_reg <= dvsr_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg[walr_pkg::QUO_BITS-1:0];

endmodule

// ----- hw/rtl/wide_antialiased_line_raster_top.sv -----
// top level: line setup, column sequencer and pixel output register
// load: one transfer, then the divider at a quotient bit per cycle and a state to take the slope,
// before the next transfer is taken; a single point skips the divide and stays ready;
// step: width+1 pixels, one per cycle while the pixel receiver is ready, through
// one output register; the next transfer is taken with the last pixel of a column
// reset: no line loaded, width 1, output empty; steps while no line is loaded give nothing
`include "wide_antialiased_line_raster_top_assert.svh"

module wide_antialiased_line_raster_top (
    input  logic        clk,
    input  logic        rst_n,
    walr_cmd_if.sink    cmd,
    walr_pix_if.source  pixel
);

    localparam int CB = walr_pkg::COORD_BITS;
    localparam int FB = walr_pkg::FRAC_BITS;
    localparam int AB = walr_pkg::ACC_BITS;
    localparam int WB = walr_pkg::WIDTH_BITS;
    localparam int PB = walr_pkg::PIX_BITS;
    localparam int CVB = walr_pkg::COV_BITS;
    localparam int SB = walr_pkg::SLOPE_BITS;

    walr_pkg::state_t   state_reg, state_next;
    logic               active_reg, active_next;
    logic               steep_reg, steep_next;
    logic               neg_reg, neg_next;
    logic [CB-1:0]      major_pos_reg, major_pos_next;
    logic [CB-1:0]      major_end_reg, major_end_next;
    logic [AB-1:0]      accum_reg, accum_next;
    logic [SB-1:0]      slope_reg, slope_next;
    logic [WB-1:0]      width_reg, width_next;
    logic [WB-1:0]      idx_reg, idx_next;

    logic               out_valid_reg, out_valid_next;
    logic [PB-1:0]      pix_x_reg, pix_x_next;
    logic [PB-1:0]      pix_y_reg, pix_y_next;
    logic [CVB-1:0]     cov_reg, cov_next;
    logic               interior_reg, interior_next;
    logic               clast_reg, clast_next;
    logic               ldone_reg, ldone_next;

    walr_pkg::div_req_t div_req;
    walr_pkg::div_rsp_t div_rsp;

    // line setup
    logic [CB-1:0]      adx, ady;
    logic               steep_in;
    logic [CB-1:0]      p0_maj, p0_min, p1_maj, p1_min;
    logic [CB-1:0]      maj_lo, maj_hi, min_lo, min_hi;
    logic [CB-1:0]      dx, mag;
    logic               neg_in;

    // column emission
    logic [CB-1:0]      ip;
    logic [FB-1:0]      frac;
    logic [PB-1:0]      minor_pix;
    logic [PB-1:0]      major_pix;
    logic               is_first, is_last, col_done;
    logic               emit_go, last_emit, in_fire, active_now;
    logic [SB-1:0]      q_signed;

    walr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        adx = (cmd.start_x >= cmd.end_x) ? cmd.start_x - cmd.end_x : cmd.end_x - cmd.start_x;
        ady = (cmd.start_y >= cmd.end_y) ? cmd.start_y - cmd.end_y : cmd.end_y - cmd.start_y;
        steep_in = (ady > adx);
        p0_maj = steep_in ? cmd.start_y : cmd.start_x;
        p0_min = steep_in ? cmd.start_x : cmd.start_y;
        p1_maj = steep_in ? cmd.end_y   : cmd.end_x;
        p1_min = steep_in ? cmd.end_x   : cmd.end_y;
        if (p0_maj > p1_maj)
        begin
            maj_lo = p1_maj;
            min_lo = p1_min;
            maj_hi = p0_maj;
            min_hi = p0_min;
        end
        else
        begin
            maj_lo = p0_maj;
            min_lo = p0_min;
            maj_hi = p1_maj;
            min_hi = p1_min;
        end
        dx     = maj_hi - maj_lo;
        neg_in = (min_hi < min_lo);
        mag    = neg_in ? min_lo - min_hi : min_hi - min_lo;
    end

    always_comb
    begin
        ip        = accum_reg[AB-1:FB];
        frac      = accum_reg[FB-1:0];
        minor_pix = {1'b0, ip} + PB'(idx_reg);
        major_pix = {1'b0, major_pos_reg};
        is_first  = (idx_reg == '0);
        is_last   = (idx_reg == width_reg);
        col_done  = (major_pos_reg == major_end_reg);
        emit_go   = (state_reg == walr_pkg::ST_EMIT) && (!out_valid_reg || pixel.ready);
        last_emit = emit_go && is_last;
        cmd.ready = (state_reg == walr_pkg::ST_IDLE) || last_emit;
        in_fire   = cmd.valid && cmd.ready;
        active_now = last_emit ? !col_done : active_reg;
        q_signed  = neg_reg ? SB'(0) - {1'b0, div_rsp.quotient} : {1'b0, div_rsp.quotient};

        div_req.start = in_fire && (cmd.command == walr_pkg::CMD_LOAD) && (dx != '0);
        div_req.mag   = mag;
        div_req.dx    = dx;
    end

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        steep_next     = steep_reg;
        neg_next       = neg_reg;
        major_pos_next = major_pos_reg;
        major_end_next = major_end_reg;
        accum_next     = accum_reg;
        slope_next     = slope_reg;
        width_next     = width_reg;
        idx_next       = idx_reg;

        out_valid_next = (out_valid_reg && !pixel.ready) || emit_go;
        pix_x_next     = pix_x_reg;
        pix_y_next     = pix_y_reg;
        cov_next       = cov_reg;
        interior_next  = interior_reg;
        clast_next     = clast_reg;
        ldone_next     = ldone_reg;

        unique case (state_reg)
            walr_pkg::ST_IDLE:
            begin
            end
            walr_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    slope_next = q_signed;
                    state_next = walr_pkg::ST_IDLE;
                end
            end
            walr_pkg::ST_EMIT:
            begin
                if (emit_go)
                begin
                    pix_x_next    = steep_reg ? minor_pix : major_pix;
                    pix_y_next    = steep_reg ? major_pix : minor_pix;
                    interior_next = !is_first && !is_last;
                    clast_next    = is_last;
                    ldone_next    = is_last && col_done;
                    if (is_first)
                        cov_next = walr_pkg::coverage_of(walr_pkg::FRAC_ONE - {1'b0, frac});
                    else if (is_last)
                        cov_next = walr_pkg::coverage_of({1'b0, frac});
                    else
                        cov_next = walr_pkg::COV_FULL;

                    if (is_last)
                    begin
                        idx_next   = '0;
                        state_next = walr_pkg::ST_IDLE;
                        if (col_done)
                            active_next = 1'b0;
                        else
                        begin
                            major_pos_next = major_pos_reg + CB'(1);
                            accum_next = accum_reg + {{(AB-SB){slope_reg[SB-1]}}, slope_reg};
                        end
                    end
                    else
                        idx_next = idx_reg + WB'(1);
                end
            end
            default:
            begin
                state_next = walr_pkg::ST_IDLE;
            end
        endcase

        // a new transfer takes over from the column just finished
        if (in_fire)
        begin
            if (cmd.command == walr_pkg::CMD_LOAD)
            begin
                active_next    = 1'b1;
                steep_next     = steep_in;
                neg_next       = neg_in;
                major_pos_next = maj_lo;
                major_end_next = maj_hi;
                accum_next     = {min_lo, {FB{1'b0}}};
                width_next     = (cmd.line_width == '0) ? walr_pkg::WIDTH_MIN : cmd.line_width;
                if (dx == '0)
                begin
                    slope_next = SB'(walr_pkg::FRAC_ONE);
                    state_next = walr_pkg::ST_IDLE;
                end
                else
                    state_next = walr_pkg::ST_DIV;
            end
            else
                state_next = active_now ? walr_pkg::ST_EMIT : walr_pkg::ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= walr_pkg::ST_IDLE;
            active_reg    <= 1'b0;
            steep_reg     <= 1'b0;
            neg_reg       <= 1'b0;
            major_pos_reg <= '0;
            major_end_reg <= '0;
            accum_reg     <= '0;
            slope_reg     <= '0;
            width_reg     <= walr_pkg::WIDTH_MIN;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            steep_reg     <= steep_next;
            neg_reg       <= neg_next;
            major_pos_reg <= major_pos_next;
            major_end_reg <= major_end_next;
            accum_reg     <= accum_next;
            slope_reg     <= slope_next;
            width_reg     <= width_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_x_reg    <= pix_x_next;
        pix_y_reg    <= pix_y_next;
        cov_reg      <= cov_next;
        interior_reg <= interior_next;
        clast_reg    <= clast_next;
        ldone_reg    <= ldone_next;
    end

    assign pixel.valid       = out_valid_reg;
    assign pixel.pixel_x     = pix_x_reg;
    assign pixel.pixel_y     = pix_y_reg;
    assign pixel.coverage    = cov_reg;
    assign pixel.interior    = interior_reg;
    assign pixel.column_last = clast_reg;
    assign pixel.line_done   = ldone_reg;

    `WALR_ASSERT_IMP(a_ready_state, cmd.ready, (state_reg == walr_pkg::ST_IDLE) || (state_reg == walr_pkg::ST_EMIT))
    `WALR_ASSERT_NXT(a_load_divides, div_req.start, (state_reg == walr_pkg::ST_DIV) && div_rsp.busy)
    `WALR_ASSERT_IMP(a_div_running, state_reg == walr_pkg::ST_DIV, div_rsp.busy || div_rsp.done)
    `WALR_ASSERT_IMP(a_interior_full, pixel.valid && pixel.interior, pixel.coverage == walr_pkg::COV_FULL)
    `WALR_ASSERT_IMP(a_emit_active, state_reg == walr_pkg::ST_EMIT, active_reg)

endmodule

// ----- dv/wide_antialiased_line_raster_top_tb.sv -----
// self-checking testbench for the wide antialiased line rasteriser
`timescale 1ns / 100ps

module wide_antialiased_line_raster_top_tb;

    localparam int     WIDTH_MAX  = 63;
    localparam int     RANDOM_ITEMS = 76;
    localparam longint UNIT_L     = longint'(1) << walr_pkg::FRAC_BITS;
    localparam longint FRAC_MASK_L = UNIT_L - 1;
    localparam longint ACC_MASK_L = (longint'(1) << walr_pkg::ACC_BITS) - 1;
    localparam longint COORD_MASK_L = (longint'(1) << walr_pkg::COORD_BITS) - 1;
    localparam int     COORD_TOP  = (1 << walr_pkg::COORD_BITS) - 1;
    localparam longint COV_FULL_L = longint'(walr_pkg::COV_FULL);

    typedef struct {
        logic                            command;
        logic [walr_pkg::COORD_BITS-1:0] start_x;
        logic [walr_pkg::COORD_BITS-1:0] start_y;
        logic [walr_pkg::COORD_BITS-1:0] end_x;
        logic [walr_pkg::COORD_BITS-1:0] end_y;
        logic [walr_pkg::WIDTH_BITS-1:0] line_width;
    } raster_cmd_t;

    typedef struct packed {
        logic [walr_pkg::PIX_BITS-1:0] x;
        logic [walr_pkg::PIX_BITS-1:0] y;
        logic [walr_pkg::COV_BITS-1:0] cov;
        logic                          interior;
        logic                          column_last;
        logic                          line_done;
    } raster_pix_t;

    typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

    class raster_scoreboard;
        bit          active = 1'b0;
        bit          steep = 1'b0;
        longint      major_pos = 0;
        longint      major_end = 0;
        longint      minor_acc = 0;
        longint      slope = 0;
        int          width_held = 1;
        raster_pix_t pending_pixels[$];
        int          failures = 0;

        function void push_pixel(longint minor, longint cov, bit inner, bit clast, bit fin);
            raster_pix_t p;
            longint px;
            longint py;
            px = steep ? minor : major_pos;
            py = steep ? major_pos : minor;
            p.x = px[walr_pkg::PIX_BITS-1:0];
            p.y = py[walr_pkg::PIX_BITS-1:0];
            p.cov = cov[walr_pkg::COV_BITS-1:0];
            p.interior = inner;
            p.column_last = clast;
            p.line_done = fin;
            pending_pixels.push_back(p);
        endfunction

        function void note_command(raster_cmd_t c);
            longint ax;
            longint ay;
            longint bx;
            longint by;
            longint t;
            longint dx;
            longint dy;
            longint adx;
            longint ady;
            longint q;
            longint ip;
            longint f;
            int     w;
            bit     fin;
            if (c.command == walr_pkg::CMD_LOAD)
            begin
                ax = longint'(c.start_x);
                ay = longint'(c.start_y);
                bx = longint'(c.end_x);
                by = longint'(c.end_y);
                adx = bx - ax;
                if (adx < 0) adx = -adx;
                ady = by - ay;
                if (ady < 0) ady = -ady;
                steep = ady > adx;
                if (steep)
                begin
                    t = ax; ax = ay; ay = t;
                    t = bx; bx = by; by = t;
                end
                if (ax > bx)
                begin
                    t = ax; ax = bx; bx = t;
                    t = ay; ay = by; by = t;
                end
                dx = bx - ax;
                dy = by - ay;
                if (dx == 0)
                begin
                    slope = UNIT_L;
                end
                else
                begin
                    q = ((dy < 0 ? -dy : dy) << walr_pkg::FRAC_BITS) / dx;
                    slope = (dy < 0) ? -q : q;
                end
                w = int'(c.line_width);
                if (w == 0) w = 1;
                if (w > WIDTH_MAX) w = WIDTH_MAX;
                width_held = w;
                major_pos = ax;
                major_end = bx;
                minor_acc = (ay << walr_pkg::FRAC_BITS) & ACC_MASK_L;
                active = 1'b1;
            end
            else if (active)
            begin
                ip = minor_acc >> walr_pkg::FRAC_BITS;
                f = minor_acc & FRAC_MASK_L;
                fin = (major_pos == major_end);
                push_pixel(ip, ((UNIT_L - f) * COV_FULL_L) >> walr_pkg::FRAC_BITS,
                           1'b0, 1'b0, 1'b0);
                for (int i = 1; i < width_held; i++)
                    push_pixel(ip + i, COV_FULL_L, 1'b1, 1'b0, 1'b0);
                push_pixel(ip + width_held, (f * COV_FULL_L) >> walr_pkg::FRAC_BITS,
                           1'b0, 1'b1, fin);
                if (fin)
                begin
                    active = 1'b0;
                end
                else
                begin
                    major_pos = (major_pos + 1) & COORD_MASK_L;
                    minor_acc = (minor_acc + slope) & ACC_MASK_L;
                end
            end
        endfunction

        function void check_pixel(raster_pix_t got);
            raster_pix_t want;
            if (pending_pixels.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected pixel: x=%0d y=%0d cov=%0d int=%0b last=%0b done=%0b",
                             got.x, got.y, got.cov, got.interior, got.column_last,
                             got.line_done);
                return;
            end
            want = pending_pixels.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.cov !== want.cov ||
                got.interior !== want.interior || got.column_last !== want.column_last ||
                got.line_done !== want.line_done)
            begin
                failures++;
                if (failures <= 10)
                    $display({"pixel mismatch: expected x=%0d y=%0d cov=%0d int=%0b last=%0b ",
                              "done=%0b, got x=%0d y=%0d cov=%0d int=%0b last=%0b done=%0b"},
                             want.x, want.y, want.cov, want.interior, want.column_last,
                             want.line_done, got.x, got.y, got.cov, got.interior,
                             got.column_last, got.line_done);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    walr_cmd_if cmd_ch ();
    walr_pix_if pix_ch ();

    wide_antialiased_line_raster_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .pixel (pix_ch)
    );

    raster_scoreboard sb = new();
    int       burst_left = 0;
    int       random_count = 0;
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_hold = 0;
    int       rx_tick = 0;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stalls: open, random or periodic, switched in stretches
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pix_ch.ready <= 1'b0;
        end
        else
        begin
            rx_tick <= rx_tick + 1;
            if (rx_hold == 0)
            begin
                rx_mode <= rx_mode_t'($urandom_range(0, 2));
                rx_hold <= $urandom_range(20, 150);
            end
            else
            begin
                rx_hold <= rx_hold - 1;
            end
            case (rx_mode)
                RX_OPEN:    pix_ch.ready <= 1'b1;
                RX_RANDOM:  pix_ch.ready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: pix_ch.ready <= ((rx_tick % 7) < 3);
                default:    pix_ch.ready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pix_ch.valid && pix_ch.ready)
            sb.check_pixel({pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.coverage,
                            pix_ch.interior, pix_ch.column_last, pix_ch.line_done});
    end

    function automatic raster_cmd_t load_cmd(int sx, int sy, int ex, int ey, int w);
        raster_cmd_t c;
        c.command = walr_pkg::CMD_LOAD;
        c.start_x = sx[walr_pkg::COORD_BITS-1:0];
        c.start_y = sy[walr_pkg::COORD_BITS-1:0];
        c.end_x = ex[walr_pkg::COORD_BITS-1:0];
        c.end_y = ey[walr_pkg::COORD_BITS-1:0];
        c.line_width = w[walr_pkg::WIDTH_BITS-1:0];
        return c;
    endfunction

    function automatic raster_cmd_t step_cmd();
        raster_cmd_t c;
        c.command = walr_pkg::CMD_STEP;
        c.start_x = walr_pkg::COORD_BITS'($urandom_range(0, COORD_TOP));
        c.start_y = walr_pkg::COORD_BITS'($urandom_range(0, COORD_TOP));
        c.end_x = walr_pkg::COORD_BITS'($urandom_range(0, COORD_TOP));
        c.end_y = walr_pkg::COORD_BITS'($urandom_range(0, COORD_TOP));
        c.line_width = walr_pkg::WIDTH_BITS'($urandom_range(0, WIDTH_MAX));
        return c;
    endfunction

    function automatic int pick_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return COORD_TOP;
        return $urandom_range(0, COORD_TOP);
    endfunction

    function automatic int near_coord(int base, int span);
        int v;
        v = base + $urandom_range(0, 2 * span) - span;
        if (v < 0) v = 0;
        if (v > COORD_TOP) v = COORD_TOP;
        return v;
    endfunction

    task automatic send_command(input raster_cmd_t c);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
            if (gap > 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= c.command;
        cmd_ch.start_x <= c.start_x;
        cmd_ch.start_y <= c.start_y;
        cmd_ch.end_x <= c.end_x;
        cmd_ch.end_y <= c.end_y;
        cmd_ch.line_width <= c.line_width;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        sb.note_command(c);
    endtask

    task automatic send_steps(input int n);
        for (int i = 0; i < n; i++)
            send_command(step_cmd());
    endtask

    task automatic run_random_lines();
        int sx;
        int sy;
        int ex;
        int ey;
        int w;
        int len;
        int kind;
        int cut;
        while (random_count < RANDOM_ITEMS)
        begin
            sx = pick_coord();
            sy = pick_coord();
            ex = near_coord(sx, $urandom_range(0, 8));
            ey = near_coord(sy, $urandom_range(0, 8));
            kind = $urandom_range(0, 5);
            if (kind < 4) w = $urandom_range(1, 6);
            else if (kind == 4) w = $urandom_range(0, WIDTH_MAX);
            else w = ($urandom_range(0, 1) != 0) ? WIDTH_MAX : 0;
            len = ((ex > sx) ? ex - sx : sx - ex);
            if (((ey > sy) ? ey - sy : sy - ey) > len) len = (ey > sy) ? ey - sy : sy - ey;
            len = len + 1;
            send_command(load_cmd(sx, sy, ex, ey, w));
            random_count++;
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                // line abandoned part way by the next load
                cut = $urandom_range(0, len - 1);
                send_steps(cut);
                random_count += cut;
            end
            else
            begin
                send_steps(len);
                random_count += len;
                if (kind == 1)
                begin
                    send_steps(1);
                    random_count++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.command <= walr_pkg::CMD_LOAD;
        cmd_ch.start_x <= '0;
        cmd_ch.start_y <= '0;
        cmd_ch.end_x <= '0;
        cmd_ch.end_y <= '0;
        cmd_ch.line_width <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_steps(1);
        send_command(load_cmd(0, 0, COORD_TOP, COORD_TOP, 1));
        send_steps(2);
        send_command(load_cmd(COORD_TOP, 0, 0, COORD_TOP, WIDTH_MAX));
        send_steps(2);
        send_command(load_cmd(7, 7, 7, 7, 0));
        send_steps(2);
        send_command(load_cmd(10, 0, 10, 3, 2));
        send_steps(4);
        send_command(load_cmd(100, 900, 103, 880, 5));
        send_steps(2);
        send_command(load_cmd(0, 512, 5, 514, 3));
        send_steps(3);
        send_command(load_cmd(COORD_TOP, COORD_TOP, COORD_TOP - 3, COORD_TOP, 1));
        send_steps(1);

        run_random_lines();
        cmd_ch.valid <= 1'b0;

        while (sb.pending_pixels.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.failures == 0 && sb.pending_pixels.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
